// ===== design/vus_pkg.sv =====
// Shared constants for the voiced / unvoiced / silence frame classifier.
// Class codes, summary row identifiers, register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package vus_pkg;

   // Width of the threshold registers and of the frame measurements.
   localparam int unsigned VALUE_W = 32;

   // Width of every reported count field.
   localparam int unsigned FIELD_W   = 20;
   localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

   // Default width of the internal statistics counters.
   localparam int unsigned COUNT_WIDTH_DEFAULT = 20;

   // Class codes.
   localparam logic [1:0] CLS_S = 2'd0;
   localparam logic [1:0] CLS_U = 2'd1;
   localparam logic [1:0] CLS_V = 2'd2;

   // Result kinds.
   localparam logic KIND_FRAME   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Summary row identifiers.
   localparam logic [2:0] ROW_ENERGY_V = 3'd0;
   localparam logic [2:0] ROW_ENERGY_U = 3'd1;
   localparam logic [2:0] ROW_ENERGY_S = 3'd2;
   localparam logic [2:0] ROW_INK_V    = 3'd3;
   localparam logic [2:0] ROW_INK_U    = 3'd4;

   // Slots of one confusion row.
   localparam logic [1:0] SLOT_TP = 2'd0;
   localparam logic [1:0] SLOT_FP = 2'd1;
   localparam logic [1:0] SLOT_FN = 2'd2;
   localparam logic [1:0] SLOT_TN = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_UPPER_ENERGY = 2'd0;
   localparam logic [1:0] CSR_LOWER_ENERGY = 2'd1;
   localparam logic [1:0] CSR_INK          = 2'd2;
   localparam logic [1:0] CSR_CERT_ONLY    = 2'd3;

endpackage

// ===== design/speech_frame_vus_classifier_stats.sv =====
// Top level of the voiced / unvoiced / silence frame classifier with statistics.
// Holds the input register, classification, counters, summary sequencer and output register.
// Depends on vus_pkg.
`timescale 1ns / 1ps

// Usage
// Each req_ transaction is one analysis frame: log energy, log ink, reference label
// and a last-frame mark. Every frame yields one rsp_ transaction with its energy and
// ink classes, the certainty flag and the reference mismatch flag. The last frame of
// a run is followed by five summary rows (energy V, U, S, then ink V, U) carrying the
// TP/FP/FN/TN counts and reference totals; the statistics are then cleared.
// A frame moves from the input register to the output register, which drives rsp_.
// Throughput: one frame per cycle while rsp_stall is low, set by the single input
// register feeding the single output register. A last frame additionally occupies
// the output register while the five summary rows leave; the next frame may enter the
// input register in that time but does not move on until the last row is loaded.
// Configuration is written through csr_ while no frame is in flight.
// Reset clears the thresholds, the mode bit, all counters and the valid flags.
// When rsp_stall is high the output register holds its transaction, and req_stall
// rises as soon as the input register is also occupied.
module speech_frame_vus_classifier_stats #(
   parameter int unsigned COUNT_WIDTH = vus_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration port
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [vus_pkg::VALUE_W-1:0]    csr_write_data,
   // frame input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [vus_pkg::VALUE_W-1:0] req_log_energy,
   input  logic signed [vus_pkg::VALUE_W-1:0] req_log_ink,
   input  logic [1:0]                     req_reference_label,
   input  logic                           req_last_frame,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_item_kind,
   output logic [1:0]                     rsp_energy_class,
   output logic [1:0]                     rsp_ink_class,
   output logic                           rsp_certain,
   output logic                           rsp_mismatch,
   output logic [2:0]                     rsp_row_id,
   output logic [vus_pkg::FIELD_W-1:0]    rsp_true_pos,
   output logic [vus_pkg::FIELD_W-1:0]    rsp_false_pos,
   output logic [vus_pkg::FIELD_W-1:0]    rsp_false_neg,
   output logic [vus_pkg::FIELD_W-1:0]    rsp_true_neg,
   output logic [vus_pkg::FIELD_W-1:0]    rsp_reference_total,
   output logic                           rsp_last_result
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Saturating increment of one counter.
   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] cnt);
      bump = (cnt != COUNT_MAX) ? cnt + 1'b1 : cnt;
   endfunction

   // Clamp a counter to the reported field width.
   function automatic logic [vus_pkg::FIELD_W-1:0] report(input logic [COUNT_WIDTH-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      report = (wide > 32'(vus_pkg::FIELD_MAX)) ? vus_pkg::FIELD_MAX
                                                : wide[vus_pkg::FIELD_W-1:0];
   endfunction

   // Configuration registers
   logic signed [vus_pkg::VALUE_W-1:0] upper_thr_ff;
   logic signed [vus_pkg::VALUE_W-1:0] lower_thr_ff;
   logic signed [vus_pkg::VALUE_W-1:0] ink_thr_ff;
   logic                               cert_only_ff;

   // Input register
   logic                               in_valid_ff;
   logic signed [vus_pkg::VALUE_W-1:0] in_energy_ff;
   logic signed [vus_pkg::VALUE_W-1:0] in_ink_ff;
   logic [1:0]                         in_ref_ff;
   logic                               in_last_ff;

   // Statistics counters
   logic [COUNT_WIDTH-1:0] e_conf_ff [3][4];
   logic [COUNT_WIDTH-1:0] e_conf_in [3][4];
   logic [COUNT_WIDTH-1:0] e_tot_ff  [3];
   logic [COUNT_WIDTH-1:0] e_tot_in  [3];
   logic [COUNT_WIDTH-1:0] k_conf_ff [2][4];
   logic [COUNT_WIDTH-1:0] k_conf_in [2][4];
   logic [COUNT_WIDTH-1:0] k_tot_ff  [2];
   logic [COUNT_WIDTH-1:0] k_tot_in  [2];

   // Summary sequencer
   logic       sum_active_ff;
   logic [2:0] sum_row_ff;

   // Output register
   logic                        rsp_valid_ff;
   logic                        rsp_kind_ff;
   logic [1:0]                  rsp_ec_ff;
   logic [1:0]                  rsp_ic_ff;
   logic                        rsp_cert_ff;
   logic                        rsp_mis_ff;
   logic [2:0]                  rsp_row_ff;
   logic [vus_pkg::FIELD_W-1:0] rsp_tp_ff;
   logic [vus_pkg::FIELD_W-1:0] rsp_fp_ff;
   logic [vus_pkg::FIELD_W-1:0] rsp_fn_ff;
   logic [vus_pkg::FIELD_W-1:0] rsp_tn_ff;
   logic [vus_pkg::FIELD_W-1:0] rsp_tot_ff;
   logic                        rsp_last_ff;

   // Handshake control
   logic out_free;
   logic advance;
   logic sum_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && out_free && !sum_active_ff;
   assign sum_done = sum_active_ff && out_free && (sum_row_ff == vus_pkg::ROW_INK_U);
   assign req_stall = in_valid_ff && !advance;

   // Frame classification
   logic [1:0] ec;
   logic [1:0] ic;
   logic       cert;
   logic       mis;
   logic       count_energy;
   logic       count_ink;

   always_comb begin
      if (in_energy_ff > upper_thr_ff) begin
         ec = vus_pkg::CLS_V;
      end else if (in_energy_ff > lower_thr_ff) begin
         ec = vus_pkg::CLS_U;
      end else begin
         ec = vus_pkg::CLS_S;
      end
      ic   = (in_ink_ff > ink_thr_ff) ? vus_pkg::CLS_U : vus_pkg::CLS_V;
      cert = (ec == ic);
      mis  = (ec != in_ref_ff);
      count_energy = (in_ref_ff <= vus_pkg::CLS_V) && (!cert_only_ff || cert);
      count_ink    = (in_ref_ff == vus_pkg::CLS_V) || (in_ref_ff == vus_pkg::CLS_U);
   end

   // Next counter values: one-versus-rest tally per row, cleared after the summary
   always_comb begin
      logic [1:0] cls;
      logic [1:0] slot;
      cls       = vus_pkg::CLS_S;
      slot      = vus_pkg::SLOT_TP;
      e_conf_in = e_conf_ff;
      e_tot_in  = e_tot_ff;
      k_conf_in = k_conf_ff;
      k_tot_in  = k_tot_ff;
      if (sum_done) begin
         for (int r = 0; r < 3; r++) begin
            e_tot_in[r] = '0;
            for (int s = 0; s < 4; s++) begin
               e_conf_in[r][s] = '0;
            end
         end
         for (int r = 0; r < 2; r++) begin
            k_tot_in[r] = '0;
            for (int s = 0; s < 4; s++) begin
               k_conf_in[r][s] = '0;
            end
         end
      end else if (advance) begin
         if (count_energy) begin
            for (int r = 0; r < 3; r++) begin
               cls = vus_pkg::CLS_V - 2'(r);
               if (in_ref_ff == cls) begin
                  slot = (ec == cls) ? vus_pkg::SLOT_TP : vus_pkg::SLOT_FN;
               end else begin
                  slot = (ec == cls) ? vus_pkg::SLOT_FP : vus_pkg::SLOT_TN;
               end
               e_conf_in[r][slot] = bump(e_conf_ff[r][slot]);
            end
            e_tot_in[vus_pkg::CLS_V - in_ref_ff] = bump(e_tot_ff[vus_pkg::CLS_V - in_ref_ff]);
         end
         if (count_ink) begin
            for (int r = 0; r < 2; r++) begin
               cls = vus_pkg::CLS_V - 2'(r);
               if (in_ref_ff == cls) begin
                  slot = (ic == cls) ? vus_pkg::SLOT_TP : vus_pkg::SLOT_FN;
               end else begin
                  slot = (ic == cls) ? vus_pkg::SLOT_FP : vus_pkg::SLOT_TN;
               end
               k_conf_in[r][slot] = bump(k_conf_ff[r][slot]);
            end
            k_tot_in[1'(vus_pkg::CLS_V - in_ref_ff)] =
               bump(k_tot_ff[1'(vus_pkg::CLS_V - in_ref_ff)]);
         end
      end
   end

   // Summary row selection
   logic [COUNT_WIDTH-1:0] row_tp;
   logic [COUNT_WIDTH-1:0] row_fp;
   logic [COUNT_WIDTH-1:0] row_fn;
   logic [COUNT_WIDTH-1:0] row_tn;
   logic [COUNT_WIDTH-1:0] row_tot;

   always_comb begin
      case (sum_row_ff)
         vus_pkg::ROW_ENERGY_V, vus_pkg::ROW_ENERGY_U, vus_pkg::ROW_ENERGY_S: begin
            row_tp  = e_conf_ff[sum_row_ff[1:0]][vus_pkg::SLOT_TP];
            row_fp  = e_conf_ff[sum_row_ff[1:0]][vus_pkg::SLOT_FP];
            row_fn  = e_conf_ff[sum_row_ff[1:0]][vus_pkg::SLOT_FN];
            row_tn  = e_conf_ff[sum_row_ff[1:0]][vus_pkg::SLOT_TN];
            row_tot = e_tot_ff[sum_row_ff[1:0]];
         end
         vus_pkg::ROW_INK_V, vus_pkg::ROW_INK_U: begin
            row_tp  = k_conf_ff[sum_row_ff[0] ^ 1'b1][vus_pkg::SLOT_TP];
            row_fp  = k_conf_ff[sum_row_ff[0] ^ 1'b1][vus_pkg::SLOT_FP];
            row_fn  = k_conf_ff[sum_row_ff[0] ^ 1'b1][vus_pkg::SLOT_FN];
            row_tn  = k_conf_ff[sum_row_ff[0] ^ 1'b1][vus_pkg::SLOT_TN];
            row_tot = k_tot_ff[sum_row_ff[0] ^ 1'b1];
         end
         default: begin
            row_tp  = '0;
            row_fp  = '0;
            row_fn  = '0;
            row_tn  = '0;
            row_tot = '0;
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_thr_ff <= '0;
         lower_thr_ff <= '0;
         ink_thr_ff   <= '0;
         cert_only_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            vus_pkg::CSR_UPPER_ENERGY: upper_thr_ff <= csr_write_data;
            vus_pkg::CSR_LOWER_ENERGY: lower_thr_ff <= csr_write_data;
            vus_pkg::CSR_INK:          ink_thr_ff   <= csr_write_data;
            vus_pkg::CSR_CERT_ONLY:    cert_only_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Input register: loaded whenever it is empty or its frame moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_energy_ff <= req_log_energy;
         in_ink_ff    <= req_log_ink;
         in_ref_ff    <= req_reference_label;
         in_last_ff   <= req_last_frame;
      end
   end

   // Statistics counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            e_tot_ff[r] <= '0;
            for (int s = 0; s < 4; s++) begin
               e_conf_ff[r][s] <= '0;
            end
         end
         for (int r = 0; r < 2; r++) begin
            k_tot_ff[r] <= '0;
            for (int s = 0; s < 4; s++) begin
               k_conf_ff[r][s] <= '0;
            end
         end
      end else begin
         e_conf_ff <= e_conf_in;
         e_tot_ff  <= e_tot_in;
         k_conf_ff <= k_conf_in;
         k_tot_ff  <= k_tot_in;
      end
   end

   // Summary sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_active_ff <= 1'b0;
         sum_row_ff    <= vus_pkg::ROW_ENERGY_V;
         rsp_valid_ff  <= 1'b0;
      end else if (out_free) begin
         if (sum_active_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff  <= vus_pkg::KIND_SUMMARY;
            rsp_ec_ff    <= '0;
            rsp_ic_ff    <= '0;
            rsp_cert_ff  <= 1'b0;
            rsp_mis_ff   <= 1'b0;
            rsp_row_ff   <= sum_row_ff;
            rsp_tp_ff    <= report(row_tp);
            rsp_fp_ff    <= report(row_fp);
            rsp_fn_ff    <= report(row_fn);
            rsp_tn_ff    <= report(row_tn);
            rsp_tot_ff   <= report(row_tot);
            rsp_last_ff  <= (sum_row_ff == vus_pkg::ROW_INK_U);
            if (sum_row_ff == vus_pkg::ROW_INK_U) begin
               sum_active_ff <= 1'b0;
               sum_row_ff    <= vus_pkg::ROW_ENERGY_V;
            end else begin
               sum_row_ff <= sum_row_ff + 3'd1;
            end
         end else begin
            rsp_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               rsp_kind_ff   <= vus_pkg::KIND_FRAME;
               rsp_ec_ff     <= ec;
               rsp_ic_ff     <= ic;
               rsp_cert_ff   <= cert;
               rsp_mis_ff    <= mis;
               rsp_row_ff    <= '0;
               rsp_tp_ff     <= '0;
               rsp_fp_ff     <= '0;
               rsp_fn_ff     <= '0;
               rsp_tn_ff     <= '0;
               rsp_tot_ff    <= '0;
               rsp_last_ff   <= !in_last_ff;
               sum_active_ff <= in_last_ff;
               sum_row_ff    <= vus_pkg::ROW_ENERGY_V;
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item_kind       = rsp_kind_ff;
   assign rsp_energy_class    = rsp_ec_ff;
   assign rsp_ink_class       = rsp_ic_ff;
   assign rsp_certain         = rsp_cert_ff;
   assign rsp_mismatch        = rsp_mis_ff;
   assign rsp_row_id          = rsp_row_ff;
   assign rsp_true_pos        = rsp_tp_ff;
   assign rsp_false_pos       = rsp_fp_ff;
   assign rsp_false_neg       = rsp_fn_ff;
   assign rsp_true_neg        = rsp_tn_ff;
   assign rsp_reference_total = rsp_tot_ff;
   assign rsp_last_result     = rsp_last_ff;

   // A last frame leaving the input register starts the summary.
   a_last_starts_summary: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (sum_active_ff && sum_row_ff == vus_pkg::ROW_ENERGY_V))
      else $error("last frame did not start the summary rows");

   // No frame moves on while summary rows are being emitted.
   a_no_frame_in_summary: assert property (@(posedge clock) disable iff (reset)
      sum_active_ff |-> !advance)
      else $error("frame advanced during summary emission");

   // The final summary row is the ink unvoiced row and marks the end of the frame's results.
   a_final_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == vus_pkg::KIND_SUMMARY && rsp_last_ff)
      |-> (rsp_row_ff == vus_pkg::ROW_INK_U))
      else $error("summary marked final on the wrong row");

   // The statistics are empty right after the last summary row is loaded.
   a_cleared_after_summary: assert property (@(posedge clock) disable iff (reset)
      sum_done |=> (e_tot_ff[0] == '0 && e_tot_ff[1] == '0 && e_tot_ff[2] == '0 &&
                    k_tot_ff[0] == '0 && k_tot_ff[1] == '0))
      else $error("statistics not cleared after summary");

endmodule

// ===== tb/tb_speech_frame_vus_classifier_stats.sv =====
// Self-checking testbench for the voiced / unvoiced / silence frame classifier.
// A scoreboard class predicts every frame result and summary row and checks each rsp_
// transaction. Depends on vus_pkg and speech_frame_vus_classifier_stats.
`timescale 1ns / 1ps

module tb_speech_frame_vus_classifier_stats;

   localparam int unsigned CNT_W        = vus_pkg::COUNT_WIDTH_DEFAULT;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned RANDOM_PHASE_ITEMS = 46;

   // A reference label outside the three classes.
   localparam logic [1:0] LABEL_INVALID = 2'd3;

   typedef logic signed [vus_pkg::VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]                   count_type;

   typedef struct packed {
      logic                        kind;
      logic [1:0]                  energy_class;
      logic [1:0]                  ink_class;
      logic                        certain;
      logic                        mismatch;
      logic [2:0]                  row_id;
      logic [vus_pkg::FIELD_W-1:0] tp;
      logic [vus_pkg::FIELD_W-1:0] fp;
      logic [vus_pkg::FIELD_W-1:0] fn;
      logic [vus_pkg::FIELD_W-1:0] tn;
      logic [vus_pkg::FIELD_W-1:0] total;
      logic                        last;
   } result_type;

   // Scoreboard: classifies each accepted frame, keeps the confusion counters and
   // queues the results that the block must return, in order.
   class frame_stats_scoreboard;
      value_type         upper_thr;
      value_type         lower_thr;
      value_type         ink_thr;
      logic              cert_only;
      count_type [11:0]  energy_conf;
      count_type [2:0]   energy_tot;
      count_type [7:0]   ink_conf;
      count_type [1:0]   ink_tot;
      result_type        pending_results[$];
      int unsigned       error_count;

      function new();
         upper_thr   = '0;
         lower_thr   = '0;
         ink_thr     = '0;
         cert_only   = 1'b0;
         error_count = 0;
         clear_counts();
      endfunction

      function void clear_counts();
         energy_conf = '0;
         energy_tot  = '0;
         ink_conf    = '0;
         ink_tot     = '0;
      endfunction

      function count_type bumped(count_type c);
         return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
      endfunction

      function logic [vus_pkg::FIELD_W-1:0] reported(count_type c);
         return (c > vus_pkg::FIELD_MAX) ? vus_pkg::FIELD_MAX : vus_pkg::FIELD_W'(c);
      endfunction

      // Picks the confusion slot for a one-versus-rest row of class cls.
      function logic [1:0] slot_of(logic [1:0] cls, logic [1:0] est, logic [1:0] label);
         if (label == cls)
            return (est == cls) ? vus_pkg::SLOT_TP : vus_pkg::SLOT_FN;
         return (est == cls) ? vus_pkg::SLOT_FP : vus_pkg::SLOT_TN;
      endfunction

      function void set_register(logic [1:0] idx, logic [vus_pkg::VALUE_W-1:0] data);
         case (idx)
            vus_pkg::CSR_UPPER_ENERGY: upper_thr = data;
            vus_pkg::CSR_LOWER_ENERGY: lower_thr = data;
            vus_pkg::CSR_INK:          ink_thr   = data;
            vus_pkg::CSR_CERT_ONLY:    cert_only = data[0];
            default: ;
         endcase
      endfunction

      // Notes an accepted frame and queues its result and, on the last frame, the
      // five summary rows.
      function void note_frame(value_type e, value_type k, logic [1:0] label, logic last);
         result_type res;
         logic [1:0] ec;
         logic [1:0] ic;
         logic [1:0] cls;
         logic [1:0] slot;
         logic       cert;
         int         r;

         // Values equal to a threshold fall into the lower class.
         if (e > upper_thr)
            ec = vus_pkg::CLS_V;
         else if (e > lower_thr)
            ec = vus_pkg::CLS_U;
         else
            ec = vus_pkg::CLS_S;
         ic   = (k > ink_thr) ? vus_pkg::CLS_U : vus_pkg::CLS_V;
         cert = (ec == ic);

         // Energy rows count valid labels, restricted to certain frames when asked.
         if (label != LABEL_INVALID && (!cert_only || cert)) begin
            for (r = 0; r < 3; r++) begin
               cls  = vus_pkg::CLS_V - r[1:0];
               slot = slot_of(cls, ec, label);
               energy_conf[r*4 + slot] = bumped(energy_conf[r*4 + slot]);
            end
            energy_tot[vus_pkg::CLS_V - label] = bumped(energy_tot[vus_pkg::CLS_V - label]);
         end

         // Ink rows ignore silence and invalid labels.
         if (label == vus_pkg::CLS_V || label == vus_pkg::CLS_U) begin
            for (r = 0; r < 2; r++) begin
               cls  = vus_pkg::CLS_V - r[1:0];
               slot = slot_of(cls, ic, label);
               ink_conf[r*4 + slot] = bumped(ink_conf[r*4 + slot]);
            end
            ink_tot[vus_pkg::CLS_V - label] = bumped(ink_tot[vus_pkg::CLS_V - label]);
         end

         res              = '0;
         res.kind         = vus_pkg::KIND_FRAME;
         res.energy_class = ec;
         res.ink_class    = ic;
         res.certain      = cert;
         res.mismatch     = (ec != label);
         res.last         = !last;
         pending_results.push_back(res);

         if (last) begin
            for (r = 0; r < 5; r++) begin
               res        = '0;
               res.kind   = vus_pkg::KIND_SUMMARY;
               res.row_id = vus_pkg::ROW_ENERGY_V + r[2:0];
               if (r < 3) begin
                  res.tp    = reported(energy_conf[r*4 + vus_pkg::SLOT_TP]);
                  res.fp    = reported(energy_conf[r*4 + vus_pkg::SLOT_FP]);
                  res.fn    = reported(energy_conf[r*4 + vus_pkg::SLOT_FN]);
                  res.tn    = reported(energy_conf[r*4 + vus_pkg::SLOT_TN]);
                  res.total = reported(energy_tot[r]);
               end else begin
                  res.tp    = reported(ink_conf[(r-3)*4 + vus_pkg::SLOT_TP]);
                  res.fp    = reported(ink_conf[(r-3)*4 + vus_pkg::SLOT_FP]);
                  res.fn    = reported(ink_conf[(r-3)*4 + vus_pkg::SLOT_FN]);
                  res.tn    = reported(ink_conf[(r-3)*4 + vus_pkg::SLOT_TN]);
                  res.total = reported(ink_tot[r-3]);
               end
               res.last = (res.row_id == vus_pkg::ROW_INK_U);
               pending_results.push_back(res);
            end
            clear_counts();
         end
      endfunction

      // Compares one result transaction with the oldest expectation.
      function void check_result(result_type seen);
         result_type want;
         logic       bad;

         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: result transaction with none expected (kind %0d row %0d)",
                        $time, seen.kind, seen.row_id);
            return;
         end
         want = pending_results.pop_front();
         bad  = (seen.kind !== want.kind) || (seen.energy_class !== want.energy_class)
             || (seen.ink_class !== want.ink_class) || (seen.certain !== want.certain)
             || (seen.mismatch !== want.mismatch) || (seen.row_id !== want.row_id)
             || (seen.tp !== want.tp) || (seen.fp !== want.fp) || (seen.fn !== want.fn)
             || (seen.tn !== want.tn) || (seen.total !== want.total)
             || (seen.last !== want.last);
         if (bad) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: result mismatch", $time);
               $display("  expected kind=%0d ec=%0d ic=%0d cert=%0d mis=%0d row=%0d",
                        want.kind, want.energy_class, want.ink_class, want.certain,
                        want.mismatch, want.row_id);
               $display("           tp=%0d fp=%0d fn=%0d tn=%0d tot=%0d last=%0d",
                        want.tp, want.fp, want.fn, want.tn, want.total, want.last);
               $display("  actual   kind=%0d ec=%0d ic=%0d cert=%0d mis=%0d row=%0d",
                        seen.kind, seen.energy_class, seen.ink_class, seen.certain,
                        seen.mismatch, seen.row_id);
               $display("           tp=%0d fp=%0d fn=%0d tn=%0d tot=%0d last=%0d",
                        seen.tp, seen.fp, seen.fn, seen.tn, seen.total, seen.last);
            end
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [1:0]                    csr_index;
   logic [vus_pkg::VALUE_W-1:0]   csr_write_data;
   logic                          req_valid;
   logic                          req_stall;
   value_type                     req_log_energy;
   value_type                     req_log_ink;
   logic [1:0]                    req_reference_label;
   logic                          req_last_frame;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_item_kind;
   logic [1:0]                    rsp_energy_class;
   logic [1:0]                    rsp_ink_class;
   logic                          rsp_certain;
   logic                          rsp_mismatch;
   logic [2:0]                    rsp_row_id;
   logic [vus_pkg::FIELD_W-1:0]   rsp_true_pos;
   logic [vus_pkg::FIELD_W-1:0]   rsp_false_pos;
   logic [vus_pkg::FIELD_W-1:0]   rsp_false_neg;
   logic [vus_pkg::FIELD_W-1:0]   rsp_true_neg;
   logic [vus_pkg::FIELD_W-1:0]   rsp_reference_total;
   logic                          rsp_last_result;

   frame_stats_scoreboard board;
   bit                    idle_on;
   int unsigned           cycle_count;

   speech_frame_vus_classifier_stats u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_log_energy      (req_log_energy),
      .req_log_ink         (req_log_ink),
      .req_reference_label (req_reference_label),
      .req_last_frame      (req_last_frame),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_energy_class    (rsp_energy_class),
      .rsp_ink_class       (rsp_ink_class),
      .rsp_certain         (rsp_certain),
      .rsp_mismatch        (rsp_mismatch),
      .rsp_row_id          (rsp_row_id),
      .rsp_true_pos        (rsp_true_pos),
      .rsp_false_pos       (rsp_false_pos),
      .rsp_false_neg       (rsp_false_neg),
      .rsp_true_neg        (rsp_true_neg),
      .rsp_reference_total (rsp_reference_total),
      .rsp_last_result     (rsp_last_result)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Every accepted result transaction goes to the scoreboard.
   always @(posedge clock) begin : collect_results
      result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_item_kind, rsp_energy_class, rsp_ink_class, rsp_certain, rsp_mismatch,
                 rsp_row_id, rsp_true_pos, rsp_false_pos, rsp_false_neg, rsp_true_neg,
                 rsp_reference_total, rsp_last_result};
         board.check_result(seen);
      end
   end

   // Receiver back-pressure in random bursts while idling is enabled.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // Register write; only called while nothing is in flight.
   task automatic write_register(input logic [1:0] idx,
                                 input logic [vus_pkg::VALUE_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      board.set_register(idx, data);
   endtask

   // Presents one frame, optionally after an idle gap, and waits for its acceptance.
   task automatic send_frame(input value_type e, input value_type k, input logic [1:0] label,
                             input logic last);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap       = $urandom_range(1, 15);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           = 1'b1;
      req_log_energy      = e;
      req_log_ink         = k;
      req_reference_label = label;
      req_last_frame      = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_frame(e, k, label, last);
      @(negedge clock);
   endtask

   // Holds the sender back until every expected result has come.
   task automatic wait_all_results();
      req_valid = 1'b0;
      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes every register with a fresh random setting.
   task automatic load_random_setting();
      value_type                   centre;
      value_type                   lower;
      value_type                   upper;
      value_type                   swap;
      value_type                   ink;
      logic [vus_pkg::VALUE_W-1:0] mode_word;
      int unsigned                 shape;

      shape  = $urandom_range(0, 5);
      centre = $signed($urandom) >>> $urandom_range(0, 12);
      lower  = centre - value_type'($urandom_range(0, 32'h0004_0000));
      upper  = centre + value_type'($urandom_range(0, 32'h0004_0000));
      ink    = centre + value_type'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      if (shape == 0) begin
         // Fully random thresholds.
         lower = $urandom;
         upper = $urandom;
         ink   = $urandom;
      end else if (shape == 1) begin
         // Lower threshold above the upper one.
         swap  = lower;
         lower = upper;
         upper = swap;
      end
      mode_word    = $urandom;
      mode_word[0] = 1'($urandom_range(0, 1));
      write_register(vus_pkg::CSR_UPPER_ENERGY, upper);
      write_register(vus_pkg::CSR_LOWER_ENERGY, lower);
      write_register(vus_pkg::CSR_INK, ink);
      write_register(vus_pkg::CSR_CERT_ONLY, mode_word);
   endtask

   // Values sit on or next to a threshold, near the midpoint of the two, or anywhere.
   function automatic value_type pick_value(value_type a, value_type b);
      value_type offs;
      offs = $urandom_range(0, 4) - 2;
      case ($urandom_range(0, 4))
         0:       return a + offs;
         1:       return b + offs;
         2:       return $urandom;
         default: return (a >>> 1) + (b >>> 1) + value_type'($urandom_range(0, 32'h2000))
                         - 32'sh1000;
      endcase
   endfunction

   function automatic logic [1:0] pick_label();
      case ($urandom_range(0, 15))
         0:       return LABEL_INVALID;
         1, 2, 3: return vus_pkg::CLS_S;
         4, 5, 6, 7, 8, 9: return vus_pkg::CLS_U;
         default: return vus_pkg::CLS_V;
      endcase
   endfunction

   // Random runs of frames, each closed by a last frame.
   task automatic run_random_phase(input int items, input bit pause_midway,
                                   input bit quiet);
      int   i;
      int   run_left;
      logic last;

      run_left = $urandom_range(1, 16);
      for (i = 0; i < items; i++) begin
         if (quiet)
            idle_on = 1'b0;
         else if (i % 20 == 0)
            idle_on = ($urandom_range(0, 2) != 0);
         if (pause_midway && i == items / 2)
            wait_all_results();
         last = (run_left == 1) || (i == items - 1);
         send_frame(pick_value(board.upper_thr, board.lower_thr),
                    pick_value(board.ink_thr, board.ink_thr), pick_label(), last);
         run_left = last ? $urandom_range(1, 16) : run_left - 1;
      end
   endtask

   initial begin : stimulus
      int phase;

      board               = new();
      idle_on             = 1'b0;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = vus_pkg::CSR_UPPER_ENERGY;
      csr_write_data      = '0;
      req_valid           = 1'b0;
      req_log_energy      = '0;
      req_log_ink         = '0;
      req_reference_label = vus_pkg::CLS_S;
      req_last_frame      = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Ordered thresholds: values on and beside each threshold, field extremes.
      write_register(vus_pkg::CSR_UPPER_ENERGY, 32'h0005_0000);
      write_register(vus_pkg::CSR_LOWER_ENERGY, 32'h0001_0000);
      write_register(vus_pkg::CSR_INK, 32'h0002_0000);
      write_register(vus_pkg::CSR_CERT_ONLY, 32'h0000_0000);
      idle_on = 1'b1;
      send_frame(32'sh0005_0000, 32'sh0002_0000, vus_pkg::CLS_U, 1'b0);
      send_frame(32'sh0005_0001, 32'sh0002_0001, vus_pkg::CLS_V, 1'b0);
      send_frame(32'sh0001_0000, 32'sh0002_0000, vus_pkg::CLS_S, 1'b0);
      send_frame(32'sh0001_0001, 32'sh0003_0000, vus_pkg::CLS_U, 1'b0);
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, LABEL_INVALID, 1'b0);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, vus_pkg::CLS_V, 1'b0);
      send_frame(32'sh0000_8000, 32'sh0007_0000, vus_pkg::CLS_S, 1'b0);
      send_frame(32'sh0006_0000, 32'sh0005_0000, vus_pkg::CLS_U, 1'b0);
      send_frame(32'sh0003_0000, -32'sh0001_0000, vus_pkg::CLS_V, 1'b1);
      wait_all_results();

      // Lower threshold above the upper one, counting certain frames only.
      write_register(vus_pkg::CSR_UPPER_ENERGY, -32'sh0001_0000);
      write_register(vus_pkg::CSR_LOWER_ENERGY, 32'h0003_0000);
      write_register(vus_pkg::CSR_INK, 32'h0000_0000);
      write_register(vus_pkg::CSR_CERT_ONLY, 32'h0000_0001);
      send_frame(-32'sh0001_0000, 32'sh0000_0000, vus_pkg::CLS_S, 1'b0);
      send_frame(-32'sh0000_ffff, 32'sh0000_0000, vus_pkg::CLS_V, 1'b0);
      send_frame(32'sh0003_0000, 32'sh0000_0001, vus_pkg::CLS_U, 1'b0);
      send_frame(32'sh0000_0000, -32'sh0000_0001, LABEL_INVALID, 1'b0);
      send_frame(32'h8000_0000, 32'sh0001_0000, vus_pkg::CLS_S, 1'b0);
      send_frame(32'sh0004_0000, -32'sh0004_0000, vus_pkg::CLS_V, 1'b1);
      wait_all_results();

      // Thresholds at the extremes of the field; mode word with upper bits set.
      write_register(vus_pkg::CSR_UPPER_ENERGY, 32'h7FFF_FFFF);
      write_register(vus_pkg::CSR_LOWER_ENERGY, 32'h8000_0000);
      write_register(vus_pkg::CSR_INK, 32'h8000_0000);
      write_register(vus_pkg::CSR_CERT_ONLY, 32'hFFFF_FFFE);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, vus_pkg::CLS_U, 1'b0);
      send_frame(32'h8000_0000, 32'h8000_0001, vus_pkg::CLS_S, 1'b0);
      send_frame(32'sh0000_0000, 32'h7FFF_FFFF, vus_pkg::CLS_V, 1'b1);
      send_frame(32'h8000_0001, 32'h8000_0000, LABEL_INVALID, 1'b1);
      send_frame(32'h7FFF_FFFE, 32'sh0000_0000, vus_pkg::CLS_U, 1'b1);
      wait_all_results();

      // Random phases with idling, one of them paused until drained midway.
      for (phase = 0; phase < 4; phase++) begin
         load_random_setting();
         run_random_phase(RANDOM_PHASE_ITEMS, phase == 1, 1'b0);
         wait_all_results();
      end

      // Final phase at full rate on both sides.
      idle_on = 1'b0;
      load_random_setting();
      run_random_phase(RANDOM_PHASE_ITEMS, 1'b0, 1'b1);
      wait_all_results();
      repeat (10) @(negedge clock);

      if (board.error_count == 0 && board.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
design/vus_pkg.sv
design/speech_frame_vus_classifier_stats.sv
tb/tb_speech_frame_vus_classifier_stats.sv
